// ===== design/gpr_pkg.sv =====
`timescale 1ns / 1ps

package gpr_pkg;

    localparam int PIX_W      = 8;
    localparam int HSUM_W     = 10;
    localparam int VSUM_W     = 12;
    localparam int DIM_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);
    localparam logic             ROUND_RST  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_ROUND_ENABLE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [HSUM_W-1:0] hsum;
        logic              y_odd;
        logic              first_row;
        logic              has_result;
        logic              row_end;
        logic              frame_end;
    } t_hitem;

endpackage

// ===== design/gpr_ram.sv =====
`timescale 1ns / 1ps

module gpr_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/gpr_front.sv =====
`timescale 1ns / 1ps

module gpr_front #(
    parameter int MAX_WIDTH = 4096,
    parameter int AW        = 11
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [gpr_pkg::PIX_W-1:0]  i_pixel_in,
    input  logic [gpr_pkg::DIM_W-1:0]  i_image_width,
    input  logic [gpr_pkg::DIM_W-1:0]  i_image_height,
    output logic                       o_s1_valid,
    output gpr_pkg::t_hitem            o_s1,
    output logic [AW-1:0]              o_s1_idx,
    input  logic                       i_s1_take
);
    import gpr_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (CW > DIM_W) ? CW : DIM_W;

    logic [CW-1:0]     r_col, n_col;
    logic [DIM_W-1:0]  r_row, n_row;
    logic [PIX_W-1:0]  r_d1, r_d2;
    logic              r_s1_valid;
    t_hitem            r_s1;
    logic [AW-1:0]     r_s1_idx;

    logic [EW-1:0]     width_ext;
    logic [CW-1:0]     w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic              col_wrap;
    logic [CW-1:0]     x;
    logic [DIM_W-1:0]  y0, y;
    logic              last_col, last_row;
    logic              have;
    logic [HSUM_W-1:0] left, hsum;
    t_hitem            item;
    logic              in_fire;

    assign width_ext = EW'(i_image_width);

    always_comb begin
        if (i_image_width == '0) begin
            w_eff = CW'(1);
        end else if (width_ext > EW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(width_ext);
        end
        if (i_image_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (i_image_height > DIM_W'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = i_image_height;
        end
    end

    always_comb begin
        col_wrap = (r_col >= w_eff);
        x        = col_wrap ? '0 : r_col;
        y0       = col_wrap ? r_row + DIM_W'(1) : r_row;
        y        = (y0 >= h_eff) ? '0 : y0;
        last_col = (x == w_eff - CW'(1));
        last_row = (y == h_eff - DIM_W'(1));

        n_col = last_col ? '0 : x + CW'(1);
        if (last_col) begin
            n_row = last_row ? '0 : y + DIM_W'(1);
        end else begin
            n_row = y;
        end

        have = x[0] | last_col;
        if (x[0]) begin
            left = (x == CW'(1)) ? HSUM_W'(r_d1) : HSUM_W'(r_d2);
            hsum = left + (HSUM_W'(r_d1) << 1) + HSUM_W'(i_pixel_in);
        end else begin
            left = (x == '0) ? HSUM_W'(i_pixel_in) : HSUM_W'(r_d1);
            hsum = left + (HSUM_W'(i_pixel_in) << 1) + HSUM_W'(i_pixel_in);
        end

        item.hsum       = hsum;
        item.y_odd      = y[0];
        item.first_row  = (y[DIM_W-1:1] == '0);
        item.has_result = y[0] | last_row;
        item.row_end    = last_col;
        item.frame_end  = last_col & last_row;
    end

    assign o_in_ready = !r_s1_valid || i_s1_take;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_d1       <= '0;
            r_d2       <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_d2       <= r_d1;
                r_d1       <= i_pixel_in;
                r_s1_valid <= have;
            end else if (i_s1_take) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1     <= item;
            r_s1_idx <= AW'(x >> 1);
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;
    assign o_s1_idx   = r_s1_idx;

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && item.frame_end) |=> (r_col == '0 && r_row == '0))
        else $error("counters did not wrap after the last pixel of a frame");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !i_s1_take) |=> (r_s1_valid && $stable(r_s1) && $stable(r_s1_idx)))
        else $error("stage one item changed while stalled");

endmodule

// ===== design/gpr_vert.sv =====
`timescale 1ns / 1ps

module gpr_vert (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s1_valid,
    input  gpr_pkg::t_hitem             i_s1,
    output logic                        o_s1_take,
    input  logic [gpr_pkg::HSUM_W-1:0]  i_upper_q,
    input  logic [gpr_pkg::HSUM_W-1:0]  i_center_q,
    input  logic                        i_round_enable,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [gpr_pkg::PIX_W-1:0]   o_pixel_out,
    output logic                        o_row_end,
    output logic                        o_frame_end
);
    import gpr_pkg::*;

    logic              r_s2_valid;
    t_hitem            r_s2;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_pixel;
    logic              r_row_end;
    logic              r_frame_end;

    logic              s3_load;
    logic              s2_fire;
    logic [VSUM_W-1:0] mid, top, bot, vsum;

    assign s3_load   = !r_out_valid || i_out_ready;
    assign s2_fire   = r_s2_valid && r_s2.has_result && s3_load;
    assign o_s1_take = !r_s2_valid || !r_s2.has_result || s3_load;

    always_comb begin
        mid  = r_s2.y_odd ? VSUM_W'(i_center_q) : VSUM_W'(r_s2.hsum);
        top  = r_s2.first_row ? mid : VSUM_W'(i_upper_q);
        bot  = r_s2.y_odd ? VSUM_W'(r_s2.hsum) : mid;
        vsum = top + (mid << 1) + bot + (i_round_enable ? VSUM_W'(8) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s1_take) begin
                r_s2_valid <= i_s1_valid;
            end
            if (s3_load) begin
                r_out_valid <= r_s2_valid && r_s2.has_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_take) begin
            r_s2 <= i_s1;
        end
        if (s2_fire) begin
            r_pixel     <= vsum[VSUM_W-1:4];
            r_row_end   <= r_s2.row_end;
            r_frame_end <= r_s2.frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_pixel;
    assign o_row_end   = r_row_end;
    assign o_frame_end = r_frame_end;

    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_frame_end) |-> r_row_end)
        else $error("frame end without row end");

    a_s2_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire |=> r_out_valid)
        else $error("result lost between stage two and output register");

endmodule

// ===== design/gray_pyramid_reduce_3x3.sv =====
`timescale 1ns / 1ps
// A result reaches the outputs through the input register, the line store read and
// the output register. Throughput: one pixel per cycle unless the output stalls,
// set by single-port-per-side line stores.
// Reset clears counters, pixel delays, pipeline valids and config to defaults;
// line stores are not cleared and need no clearing pass.
module gray_pyramid_reduce_3x3 #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [gpr_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [gpr_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                          o_row_end,
    output logic                          o_frame_end,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gpr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gpr_pkg::DIM_W-1:0]     i_cfg_data
);
    import gpr_pkg::*;

    localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [DIM_W-1:0]  r_image_width;
    logic [DIM_W-1:0]  r_image_height;
    logic              r_round_enable;

    logic              s1_valid;
    t_hitem            s1;
    logic [AW-1:0]     s1_idx;
    logic              s1_take;
    logic              upper_we, center_we;
    logic [HSUM_W-1:0] upper_q, center_q;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RST;
            r_image_height <= HEIGHT_RST;
            r_round_enable <= ROUND_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                CFG_ROUND_ENABLE: r_round_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    gpr_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel_in     (i_pixel_in),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_s1_valid     (s1_valid),
        .o_s1           (s1),
        .o_s1_idx       (s1_idx),
        .i_s1_take      (s1_take)
    );

    assign upper_we  = s1_valid && s1_take && s1.y_odd;
    assign center_we = s1_valid && s1_take && !s1.y_odd;

    gpr_ram #(
        .WIDTH (HSUM_W),
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_upper_ram (
        .i_clk   (i_clk),
        .i_we    (upper_we),
        .i_waddr (s1_idx),
        .i_wdata (s1.hsum),
        .i_re    (s1_take),
        .i_raddr (s1_idx),
        .o_rdata (upper_q)
    );

    gpr_ram #(
        .WIDTH (HSUM_W),
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_center_ram (
        .i_clk   (i_clk),
        .i_we    (center_we),
        .i_waddr (s1_idx),
        .i_wdata (s1.hsum),
        .i_re    (s1_take),
        .i_raddr (s1_idx),
        .o_rdata (center_q)
    );

    gpr_vert u_vert (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s1_valid     (s1_valid),
        .i_s1           (s1),
        .o_s1_take      (s1_take),
        .i_upper_q      (upper_q),
        .i_center_q     (center_q),
        .i_round_enable (r_round_enable),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_out    (o_pixel_out),
        .o_row_end      (o_row_end),
        .o_frame_end    (o_frame_end)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import gpr_pkg::*;

    localparam int MAX_WIDTH     = 4096;
    localparam int STORE_DEPTH   = (MAX_WIDTH + 1) / 2;
    localparam int SETTLE        = 8;
    localparam int RANDOM_PIXELS = 1000;

    typedef enum logic [1:0] {OP_PIXEL, OP_CFG, OP_DRAIN} t_op_kind;
    typedef enum logic [1:0] {FILL_RANDOM, FILL_MAX, FILL_ZERO, FILL_CHECKER} t_fill;

    typedef struct packed {
        t_op_kind         kind;
        t_cfg_idx         index;
        logic [DIM_W-1:0] data;
        logic [PIX_W-1:0] pix;
    } t_op;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             row_end;
        logic             frame_end;
    } t_reduced;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [PIX_W-1:0]     i_pixel_in  = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DIM_W-1:0]     i_cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [PIX_W-1:0]     o_pixel_out;
    logic                 o_row_end;
    logic                 o_frame_end;
    logic                 o_cfg_ready;

    t_op      op_queue[$];
    t_reduced pending_results[$];
    int       mismatches  = 0;
    int       gap_left    = 0;
    int       stall_left  = 0;
    int       send_burst  = 0;
    int       recv_burst  = 0;
    int       since_pixel = 0;

    logic [HSUM_W-1:0] upper_sums  [STORE_DEPTH];
    logic [HSUM_W-1:0] center_sums [STORE_DEPTH];
    logic [PIX_W-1:0]  last_pix;
    logic [PIX_W-1:0]  last_pix2;
    int                col_pos;
    int                row_pos;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic              round_reg;

    gray_pyramid_reduce_3x3 #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel_in  (i_pixel_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel_out (o_pixel_out),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int max_v);
        if (v == 0) return 1;
        return (v > max_v) ? max_v : int'(v);
    endfunction

    function automatic int pick_delay(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 2) begin
            burst = $urandom_range(200, 20);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic bit reduce_pixel(input logic [PIX_W-1:0] px, output t_reduced res);
        int w, h, x, y, left, c, hsum, top, mid, vsum, v;
        bit have, emit;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        have = 1'b0;
        emit = 1'b0;
        hsum = 0;
        vsum = 0;
        c = 0;
        res = '0;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        x = col_pos;
        y = row_pos;
        if (x % 2 == 1) begin
            left = (x == 1) ? last_pix : last_pix2;
            c = x - 1;
            hsum = left + 2 * last_pix + px;
            have = 1'b1;
        end else if (x == w - 1) begin
            left = (x == 0) ? px : last_pix;
            c = x;
            hsum = left + 3 * px;
            have = 1'b1;
        end
        if (have) begin
            if (y % 2 == 1) begin
                mid = center_sums[c / 2];
                top = (y == 1) ? mid : upper_sums[c / 2];
                vsum = top + 2 * mid + hsum;
                upper_sums[c / 2] = HSUM_W'(hsum);
                emit = 1'b1;
            end else begin
                center_sums[c / 2] = HSUM_W'(hsum);
                if (y == h - 1) begin
                    top = (y == 0) ? hsum : upper_sums[c / 2];
                    vsum = top + 3 * hsum;
                    emit = 1'b1;
                end
            end
        end
        if (emit) begin
            v = (vsum + (round_reg ? 8 : 0)) >> 4;
            res.pix = PIX_W'((v > 255) ? 255 : v);
            res.row_end = (x == w - 1);
            res.frame_end = (x == w - 1) && (y == h - 1);
        end
        last_pix2 = last_pix;
        last_pix = px;
        col_pos = x + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = y + 1;
            if (row_pos >= h) row_pos = 0;
        end
        return emit;
    endfunction

    function automatic void push_cfg(input t_cfg_idx idx, input int value);
        t_op op;
        op = '0;
        op.kind = OP_CFG;
        op.index = idx;
        op.data = DIM_W'(value);
        op_queue.push_back(op);
    endfunction

    function automatic void push_drain();
        t_op op;
        op = '0;
        op.kind = OP_DRAIN;
        op_queue.push_back(op);
    endfunction

    function automatic int push_frame(input int w_reg, input int h_reg, input t_fill fill,
                                      input bit drain_inside);
        int w, h, cut;
        t_op op;
        w = clamp_dim(DIM_W'(w_reg), MAX_WIDTH);
        h = clamp_dim(DIM_W'(h_reg), MAX_HEIGHT);
        cut = drain_inside ? $urandom_range(w * h - 1) : -1;
        op = '0;
        op.kind = OP_PIXEL;
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                if (r * w + c == cut) push_drain();
                case (fill)
                    FILL_MAX:     op.pix = '1;
                    FILL_ZERO:    op.pix = '0;
                    FILL_CHECKER: op.pix = ((r + c) % 2 != 0) ? 8'hFF : 8'h00;
                    default:      op.pix = PIX_W'($urandom_range(255));
                endcase
                op_queue.push_back(op);
            end
        end
        return w * h;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : driver
        logic pix_hold;
        logic cfg_hold;
        bit   quiet;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_cfg_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            pix_hold = i_in_valid && !o_in_ready;
            cfg_hold = i_cfg_valid && !o_cfg_ready;
            quiet = !i_in_valid && since_pixel >= SETTLE && pending_results.size() == 0;
            if (!pix_hold && !cfg_hold) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (op_queue.size() != 0) begin
                    case (op_queue[0].kind)
                        OP_PIXEL: begin
                            i_pixel_in <= op_queue[0].pix;
                            pix_hold = 1'b1;
                            gap_left <= pick_delay(send_burst);
                            void'(op_queue.pop_front());
                        end
                        OP_CFG: if (quiet) begin
                            i_cfg_index <= op_queue[0].index;
                            i_cfg_data <= op_queue[0].data;
                            cfg_hold = 1'b1;
                            void'(op_queue.pop_front());
                        end
                        OP_DRAIN: if (quiet) begin
                            void'(op_queue.pop_front());
                        end
                        default: ;
                    endcase
                end
            end
            i_in_valid <= pix_hold;
            i_cfg_valid <= cfg_hold;
        end
    end

    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            stall_left <= pick_delay(recv_burst);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_reduced res;
        t_reduced want;
        if (!i_rst_n) begin
            pending_results.delete();
            last_pix = '0;
            last_pix2 = '0;
            col_pos = 0;
            row_pos = 0;
            width_reg = WIDTH_RST;
            height_reg = HEIGHT_RST;
            round_reg = ROUND_RST;
            since_pixel <= SETTLE;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_IMAGE_WIDTH:  width_reg = i_cfg_data;
                    CFG_IMAGE_HEIGHT: height_reg = i_cfg_data;
                    CFG_ROUND_ENABLE: round_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                since_pixel <= 0;
                if (reduce_pixel(i_pixel_in, res)) pending_results.push_back(res);
            end else if (since_pixel < SETTLE) begin
                since_pixel <= since_pixel + 1;
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("beat with nothing pending, pixel_out", o_pixel_out, -1);
                end else begin
                    want = pending_results.pop_front();
                    if (o_pixel_out !== want.pix)
                        flag_mismatch("pixel_out", o_pixel_out, want.pix);
                    if (o_row_end !== want.row_end)
                        flag_mismatch("row_end", o_row_end, want.row_end);
                    if (o_frame_end !== want.frame_end)
                        flag_mismatch("frame_end", o_frame_end, want.frame_end);
                end
            end
        end
    end

    initial begin
        int    w;
        int    h;
        int    total;
        int    pick;
        bit    first;
        t_fill fill;

        // zero sizes act as one pixel
        push_cfg(CFG_IMAGE_WIDTH, 0);
        push_cfg(CFG_IMAGE_HEIGHT, 0);
        push_cfg(CFG_ROUND_ENABLE, 1);
        void'(push_frame(0, 0, FILL_MAX, 1'b0));
        push_cfg(CFG_IMAGE_WIDTH, 3);
        push_cfg(CFG_IMAGE_HEIGHT, 3);
        push_cfg(CFG_ROUND_ENABLE, 0);
        void'(push_frame(3, 3, FILL_CHECKER, 1'b0));
        push_cfg(CFG_IMAGE_WIDTH, 4);
        push_cfg(CFG_IMAGE_HEIGHT, 2);
        void'(push_frame(4, 2, FILL_MAX, 1'b0));
        push_cfg(CFG_ROUND_ENABLE, 1);
        push_cfg(CFG_IMAGE_WIDTH, 5);
        push_cfg(CFG_IMAGE_HEIGHT, 1);
        void'(push_frame(5, 1, FILL_RANDOM, 1'b0));

        // oversize registers saturate; run short partial frames, then restart at row 0
        push_cfg(CFG_IMAGE_WIDTH, 8191);
        push_cfg(CFG_IMAGE_HEIGHT, 1);
        void'(push_frame(40, 1, FILL_RANDOM, 1'b0));
        push_cfg(CFG_IMAGE_WIDTH, 4097);
        void'(push_frame(40, 1, FILL_RANDOM, 1'b1));
        push_cfg(CFG_IMAGE_WIDTH, 2);
        push_cfg(CFG_IMAGE_HEIGHT, 8191);
        void'(push_frame(2, 20, FILL_RANDOM, 1'b1));
        push_cfg(CFG_IMAGE_WIDTH, 3);
        push_cfg(CFG_IMAGE_HEIGHT, 1);
        void'(push_frame(3, 1, FILL_RANDOM, 1'b0));
        push_cfg(CFG_IMAGE_WIDTH, 4096);
        push_cfg(CFG_IMAGE_HEIGHT, 8191);

        push_drain();
        w = 4;
        h = 4;
        total = 0;
        first = 1'b1;
        while (total < RANDOM_PIXELS) begin
            if (first || $urandom_range(2) == 0) begin
                w = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
                h = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 1);
                push_cfg(CFG_IMAGE_WIDTH, w);
                push_cfg(CFG_IMAGE_HEIGHT, h);
            end
            if (first || $urandom_range(3) == 0)
                push_cfg(CFG_ROUND_ENABLE, $urandom_range(1));
            first = 1'b0;
            if ($urandom_range(9) == 0) push_drain();
            pick = $urandom_range(15);
            case (pick)
                0:       fill = FILL_MAX;
                1:       fill = FILL_ZERO;
                2:       fill = FILL_CHECKER;
                default: fill = FILL_RANDOM;
            endcase
            total += push_frame(w, h, fill, $urandom_range(7) == 0);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (op_queue.size() != 0 || i_in_valid || i_cfg_valid || pending_results.size() != 0)
            @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
